[design/drae_pkg.sv]
// ----------------------------------------------------------------------------
// drae_pkg
// shared constants, command codes and state type for the debug register
// access executor
// ----------------------------------------------------------------------------
package drae_pkg;

    localparam int STORE_WORDS = 1024;

    localparam int ADDR_W      = 32;
    localparam int WORD_ADDR_W = ADDR_W - 2;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 4;
    localparam int LENGTH_W    = 3;
    localparam int CODE_W      = COUNT_W + 2;

    localparam int IDX_W      = $clog2(STORE_WORDS);
    localparam int REM_W      = IDX_W + 1;
    localparam bit STORE_POW2 = (STORE_WORDS == (1 << IDX_W));

    // reciprocal for the word index reduction when the store is not a power of two
    localparam int          RECIP_SHIFT = WORD_ADDR_W + IDX_W;
    localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(STORE_WORDS);
    localparam logic [31:0] RECIP       = RECIP_FULL[31:0];
    localparam int          PROD_W      = WORD_ADDR_W + 32;

    localparam logic [REM_W-1:0] REM_N     = REM_W'(STORE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STORE_WORDS - 1);

    localparam logic [CODE_W-1:0] CMD_READ_WORD  = 6'd16;
    localparam logic [CODE_W-1:0] CMD_READ_BYTE  = 6'd17;
    localparam logic [CODE_W-1:0] CMD_READ_HALF  = 6'd18;
    localparam logic [CODE_W-1:0] CMD_BIT_SET    = 6'd20;
    localparam logic [CODE_W-1:0] CMD_WRITE_BYTE = 6'd21;
    localparam logic [CODE_W-1:0] CMD_BIT_CLEAR  = 6'd22;
    localparam logic [CODE_W-1:0] CMD_WRITE_HALF = 6'd24;
    localparam logic [CODE_W-1:0] CMD_WRITE_WORD = 6'd32;
    localparam logic [CODE_W-1:0] CMD_OR_WORD    = 6'd33;
    localparam logic [CODE_W-1:0] CMD_AND_WORD   = 6'd34;
    localparam logic [CODE_W-1:0] CMD_MASK_MOD   = 6'd48;

    localparam logic [LENGTH_W-1:0] LEN_BYTE = 3'd1;
    localparam logic [LENGTH_W-1:0] LEN_HALF = 3'd2;
    localparam logic [LENGTH_W-1:0] LEN_WORD = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_EXEC
    } state_t;

endpackage

[design/debug_register_access_executor.sv]
// ----------------------------------------------------------------------------
// debug_register_access_executor
// executes one decoded debug access command against a word store
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Reads give one
// result on read_value and read_length, marked by result_strobe for a single
// cycle; the receiver cannot stall, so the result must be captured then.
// Writes and modifies give no result, and unknown codes are ignored. With the
// default power-of-two store size, a request first reads the word from the
// synchronous store and then modifies it and writes it back in ST_EXEC. With
// a store size that is not a power of two, the word index is first reduced
// by a reciprocal multiply in the further states ST_MUL and ST_REM. After
// reset the block is busy while the store is cleared one word a cycle, all
// STORE_WORDS words (1024 with the default size).
// ----------------------------------------------------------------------------
module debug_register_access_executor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [drae_pkg::ADDR_W-1:0]    target_address,
    input  logic [drae_pkg::COUNT_W-1:0]   byte_count,
    input  logic [drae_pkg::DATA_W-1:0]    first_operand,
    input  logic [drae_pkg::DATA_W-1:0]    second_operand,
    output logic                           result_strobe,
    output logic [drae_pkg::DATA_W-1:0]    read_value,
    output logic [drae_pkg::LENGTH_W-1:0]  read_length
);

    drae_pkg::state_t state_reg, state_next;

    logic [drae_pkg::IDX_W-1:0]  clear_cnt_reg, clear_cnt_next;
    logic [drae_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        strobe_reg, strobe_next;

    logic [drae_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [drae_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [drae_pkg::DATA_W-1:0]   op1_reg, op1_next;
    logic [drae_pkg::DATA_W-1:0]   op2_reg, op2_next;
    logic [drae_pkg::PROD_W-1:0]   prod1_reg, prod1_next;
    logic [drae_pkg::REM_W-1:0]    prod2_reg, prod2_next;
    logic [drae_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [drae_pkg::LENGTH_W-1:0] length_reg, length_next;

    logic [drae_pkg::DATA_W-1:0] store_mem [drae_pkg::STORE_WORDS];
    logic [drae_pkg::DATA_W-1:0] rd_data_reg;
    logic                        mem_re;
    logic                        mem_we;
    logic [drae_pkg::IDX_W-1:0]  mem_raddr;
    logic [drae_pkg::IDX_W-1:0]  mem_waddr;
    logic [drae_pkg::DATA_W-1:0] mem_wdata;

    logic                              accept;
    logic [drae_pkg::WORD_ADDR_W-1:0]  quot;
    logic [drae_pkg::REM_W-1:0]        rem_raw;
    logic [drae_pkg::REM_W-1:0]        rem_fix;
    logic [drae_pkg::CODE_W-1:0]       code;
    logic [drae_pkg::DATA_W-1:0]       bit_mask;
    logic                              bit_ok;

    assign busy          = (state_reg != drae_pkg::ST_IDLE);
    assign accept        = start && !busy;
    assign result_strobe = strobe_reg;
    assign read_value    = value_reg;
    assign read_length   = length_reg;

    // word index reduction by reciprocal
    assign quot    = drae_pkg::WORD_ADDR_W'(prod1_reg >> drae_pkg::RECIP_SHIFT);
    assign rem_raw = drae_pkg::REM_W'(addr_reg[drae_pkg::ADDR_W-1:2]) - prod2_reg;
    assign rem_fix = (rem_raw >= drae_pkg::REM_N) ? (rem_raw - drae_pkg::REM_N) : rem_raw;

    assign code     = {count_reg, addr_reg[1:0]};
    assign bit_ok   = (op1_reg[7:5] == 3'd0);
    assign bit_mask = drae_pkg::DATA_W'(1) << op1_reg[4:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drae_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        count_reg  <= count_next;
        op1_reg    <= op1_next;
        op2_reg    <= op2_next;
        prod1_reg  <= prod1_next;
        prod2_reg  <= prod2_next;
        value_reg  <= value_next;
        length_reg <= length_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        idx_next       = idx_reg;
        strobe_next    = 1'b0;
        addr_next      = addr_reg;
        count_next     = count_reg;
        op1_next       = op1_reg;
        op2_next       = op2_reg;
        prod1_next     = prod1_reg;
        prod2_next     = prod2_reg;
        value_next     = value_reg;
        length_next    = length_reg;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rd_data_reg;

        case (state_reg)
            drae_pkg::ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = clear_cnt_reg;
                mem_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == drae_pkg::LAST_IDX)
                begin
                    state_next = drae_pkg::ST_IDLE;
                end
            end

            drae_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = target_address;
                    count_next = byte_count;
                    op1_next   = first_operand;
                    op2_next   = second_operand;
                    if (drae_pkg::STORE_POW2)
                    begin
                        idx_next   = target_address[drae_pkg::IDX_W+1:2];
                        mem_re     = 1'b1;
                        mem_raddr  = target_address[drae_pkg::IDX_W+1:2];
                        state_next = drae_pkg::ST_EXEC;
                    end
                    else
                    begin
                        prod1_next = drae_pkg::PROD_W'(target_address[drae_pkg::ADDR_W-1:2])
                                   * drae_pkg::PROD_W'(drae_pkg::RECIP);
                        state_next = drae_pkg::ST_MUL;
                    end
                end
            end

            drae_pkg::ST_MUL:
            begin
                prod2_next = drae_pkg::REM_W'(quot) * drae_pkg::REM_N;
                state_next = drae_pkg::ST_REM;
            end

            drae_pkg::ST_REM:
            begin
                idx_next   = rem_fix[drae_pkg::IDX_W-1:0];
                mem_re     = 1'b1;
                mem_raddr  = rem_fix[drae_pkg::IDX_W-1:0];
                state_next = drae_pkg::ST_EXEC;
            end

            drae_pkg::ST_EXEC:
            begin
                state_next = drae_pkg::ST_IDLE;
                case (code)
                    drae_pkg::CMD_READ_WORD:
                    begin
                        strobe_next = 1'b1;
                        value_next  = rd_data_reg;
                        length_next = drae_pkg::LEN_WORD;
                    end
                    drae_pkg::CMD_READ_BYTE:
                    begin
                        strobe_next = 1'b1;
                        value_next  = {24'd0, rd_data_reg[7:0]};
                        length_next = drae_pkg::LEN_BYTE;
                    end
                    drae_pkg::CMD_READ_HALF:
                    begin
                        strobe_next = 1'b1;
                        value_next  = {16'd0, rd_data_reg[15:0]};
                        length_next = drae_pkg::LEN_HALF;
                    end
                    drae_pkg::CMD_WRITE_BYTE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_data_reg[31:8], op1_reg[7:0]};
                    end
                    drae_pkg::CMD_WRITE_HALF:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_data_reg[31:16], op1_reg[15:0]};
                    end
                    drae_pkg::CMD_WRITE_WORD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = op1_reg;
                    end
                    drae_pkg::CMD_BIT_SET:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = bit_ok ? (rd_data_reg | bit_mask) : rd_data_reg;
                    end
                    drae_pkg::CMD_BIT_CLEAR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = bit_ok ? (rd_data_reg & ~bit_mask) : rd_data_reg;
                    end
                    drae_pkg::CMD_OR_WORD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg | op1_reg;
                    end
                    drae_pkg::CMD_AND_WORD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg & op1_reg;
                    end
                    drae_pkg::CMD_MASK_MOD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = (rd_data_reg & ~op1_reg) | op2_reg;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end

            default:
            begin
                state_next = drae_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
